### design/motor_feedback_multiturn_decoder_core_macros.svh
// Assertion macros used by the motor feedback decoder core.
`ifndef MOTOR_FEEDBACK_MULTITURN_DECODER_CORE_MACROS_SVH
`define MOTOR_FEEDBACK_MULTITURN_DECODER_CORE_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define MFMD_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Checks that a condition implies another in the same cycle.
`define MFMD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition implies another in the next cycle.
`define MFMD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/mfmd_pkg.sv
// Types and constants shared by the motor feedback decoder modules.
`timescale 1ns / 1ps
`default_nettype none
package mfmd_pkg;

    localparam int ID_W     = 11;
    localparam int SLOT_W   = 3;
    localparam int CFG_REGS = 5;
    localparam int CFG_AW   = 5;
    localparam int APB_DW   = 32;

    // Register indexes, which are also the motor slot numbers.
    localparam logic [SLOT_W-1:0] CFG_YAW      = 3'd0;
    localparam logic [SLOT_W-1:0] CFG_PITCH    = 3'd1;
    localparam logic [SLOT_W-1:0] CFG_TRIGGER  = 3'd2;
    localparam logic [SLOT_W-1:0] CFG_FRIC_ONE = 3'd3;
    localparam logic [SLOT_W-1:0] CFG_FRIC_TWO = 3'd4;

    typedef logic [ID_W-1:0] t_id;
    localparam t_id CFG_RESET [CFG_REGS] = '{11'd517, 11'd518, 11'd519, 11'd513, 11'd514};

    localparam int ENC_BITS   = 13;
    localparam int ENC_COUNTS = 1 << ENC_BITS;
    localparam int ENC_HALF   = ENC_COUNTS / 2;
    localparam int FINE_FULL  = 368640;
    localparam int FINE_GAIN  = FINE_FULL / ENC_COUNTS;
    localparam int VEL_GAIN   = 357;
    localparam int GIMBAL_JUMP  = 1000;
    localparam int SHOOTER_JUMP = 4096;

    localparam int TOTAL_W = 30;
    localparam int FINE_W  = 35;
    localparam int VEL_W   = 25;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } t_match;

    typedef struct packed {
        logic [15:0]        last_angle;
        logic signed [15:0] turns;
    } t_slot_state;

    typedef struct packed {
        logic                      hit;
        logic [SLOT_W-1:0]         slot;
        logic                      friction;
        logic signed [15:0]        rpm;
        logic signed [15:0]        cur;
        logic [7:0]                temp;
        logic signed [15:0]        turns;
        logic signed [TOTAL_W-1:0] total;
        logic signed [15:0]        ref_angle;
    } t_s2_req;

endpackage
`default_nettype wire

### design/motor_feedback_multiturn_decoder_core.sv
// Order: match and store read, turn update, then scaling into the output
// register that drives o_valid; i_stall can hold each stage on the way.
// Throughput: one request per cycle while o_stall is low; the turn store is
// read as a request is taken, and a write to the same motor then is forwarded into the read.
// Reset (synchronous, active low) restores the default motor IDs, marks
// every motor's stored angle and turns as zero and clears the reference.
`timescale 1ns / 1ps
`default_nettype none
`include "motor_feedback_multiturn_decoder_core_macros.svh"
module motor_feedback_multiturn_decoder_core #(
    parameter int MOTOR_SLOTS = 5
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [mfmd_pkg::CFG_AW-1:0]    paddr,
    input  wire logic [mfmd_pkg::APB_DW-1:0]    pwdata,
    output logic      [mfmd_pkg::APB_DW-1:0]    prdata,
    output logic                                pready,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [mfmd_pkg::ID_W-1:0]      i_frame_id,
    input  wire logic [15:0]                    i_angle_word,
    input  wire logic [15:0]                    i_speed_word,
    input  wire logic [15:0]                    i_current_word,
    input  wire logic [7:0]                     i_temperature_byte,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic                                o_matched,
    output logic        [mfmd_pkg::SLOT_W-1:0]  o_motor_slot,
    output logic signed [15:0]                  o_rotor_speed,
    output logic signed [15:0]                  o_torque_current,
    output logic        [7:0]                   o_temperature,
    output logic signed [15:0]                  o_turn_count,
    output logic signed [mfmd_pkg::TOTAL_W-1:0] o_total_position,
    output logic signed [mfmd_pkg::FINE_W-1:0]  o_angle_fine,
    output logic signed [mfmd_pkg::VEL_W-1:0]   o_spin_rate,
    output logic signed [15:0]                  o_reference_angle
);
    import mfmd_pkg::*;

    localparam int AW = (MOTOR_SLOTS > 1) ? $clog2(MOTOR_SLOTS) : 1;
    localparam logic [SLOT_W+1:0] SLOT_LIMIT = (SLOT_W + 2)'(MOTOR_SLOTS);

    t_match      in_match;
    logic        in_hit;
    logic        accept;
    logic        s1_free;
    logic        s1_move;
    logic        s2_free;
    logic        out_busy;
    t_slot_state ram_rd;
    t_slot_state ram_wr;
    logic        ram_wr_en;

    logic               r_s1_vld;
    logic               r_s1_hit;
    logic [SLOT_W-1:0]  r_s1_slot;
    logic [15:0]        r_s1_angle;
    logic [15:0]        r_s1_speed;
    logic [15:0]        r_s1_current;
    logic [7:0]         r_s1_temp;

    logic               r_s2_vld;
    t_s2_req            r_s2;
    t_s2_req            n_s2;

    logic               r_first_taken;
    logic signed [15:0] r_first_angle;

    logic               gimbal;
    logic               friction;
    logic signed [16:0] ang;
    logic signed [16:0] prev;
    logic signed [17:0] diff;
    logic signed [17:0] jump;
    logic signed [15:0] t_new;
    logic signed [16:0] turn_step;
    logic signed [15:0] ref_now;
    logic               take_first;

    mfmd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_frame_id (i_frame_id),
        .o_match    (in_match)
    );

    // A slot without storage counts as no match.
    assign in_hit = in_match.hit && ((SLOT_W + 2)'(in_match.slot) < SLOT_LIMIT);

    assign s2_free = !r_s2_vld || !out_busy;
    assign s1_move = r_s1_vld && s2_free;
    assign s1_free = !r_s1_vld || s2_free;
    assign o_stall = !s1_free;
    assign accept  = i_valid && s1_free;

    assign ram_wr_en = s1_move && r_s1_hit;
    assign ram_wr    = '{last_angle: r_s1_angle, turns: t_new};

    mfmd_state_ram #(
        .DEPTH (MOTOR_SLOTS),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept && in_hit),
        .i_rd_addr (AW'(in_match.slot)),
        .o_rd_data (ram_rd),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (AW'(r_s1_slot)),
        .i_wr_data (ram_wr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s1_free) begin
            r_s1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_hit     <= in_hit;
            r_s1_slot    <= in_match.slot;
            r_s1_angle   <= i_angle_word;
            r_s1_speed   <= i_speed_word;
            r_s1_current <= i_current_word;
            r_s1_temp    <= i_temperature_byte;
        end
    end

    // Turn tracking: gimbal angles are signed, shooter angles unsigned.
    always_comb begin
        gimbal   = (r_s1_slot == CFG_YAW) || (r_s1_slot == CFG_PITCH);
        friction = (r_s1_slot == CFG_FRIC_ONE) || (r_s1_slot == CFG_FRIC_TWO);
        ang  = gimbal ? $signed({r_s1_angle[15], r_s1_angle})
                      : $signed({1'b0, r_s1_angle});
        prev = gimbal ? $signed({ram_rd.last_angle[15], ram_rd.last_angle})
                      : $signed({1'b0, ram_rd.last_angle});
        diff = 18'(ang) - 18'(prev);
        jump = gimbal ? 18'(GIMBAL_JUMP) : 18'(SHOOTER_JUMP);
        t_new = ram_rd.turns;
        if (diff < -jump) begin
            if (ram_rd.turns != 16'sh7fff) begin
                t_new = ram_rd.turns + 16'sd1;
            end
        end else if (diff > jump) begin
            if (ram_rd.turns != 16'sh8000) begin
                t_new = ram_rd.turns - 16'sd1;
            end
        end
        turn_step  = 17'(t_new) - 17'(ram_rd.turns);
        take_first = r_s1_hit && gimbal && !r_first_taken;
        ref_now    = take_first ? $signed(r_s1_angle) : r_first_angle;

        n_s2 = '0;
        n_s2.ref_angle = ref_now;
        if (r_s1_hit) begin
            n_s2.hit      = 1'b1;
            n_s2.slot     = r_s1_slot;
            n_s2.friction = friction;
            n_s2.rpm      = $signed(r_s1_speed);
            n_s2.cur      = gimbal ? $signed(r_s1_current) : '0;
            n_s2.temp     = gimbal ? r_s1_temp : '0;
            n_s2.turns    = t_new;
            n_s2.total    = $signed({t_new[15], t_new, {ENC_BITS{1'b0}}})
                          + TOTAL_W'(ang);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_taken <= 1'b0;
            r_first_angle <= '0;
            r_s2_vld      <= 1'b0;
        end else begin
            if (s1_move && take_first) begin
                r_first_taken <= 1'b1;
                r_first_angle <= $signed(r_s1_angle);
            end
            if (s2_free) begin
                r_s2_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_s2 <= n_s2;
        end
    end

    mfmd_out_stage u_out (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_req_vld         (r_s2_vld),
        .i_req             (r_s2),
        .o_busy            (out_busy),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_matched         (o_matched),
        .o_motor_slot      (o_motor_slot),
        .o_rotor_speed     (o_rotor_speed),
        .o_torque_current  (o_torque_current),
        .o_temperature     (o_temperature),
        .o_turn_count      (o_turn_count),
        .o_total_position  (o_total_position),
        .o_angle_fine      (o_angle_fine),
        .o_spin_rate       (o_spin_rate),
        .o_reference_angle (o_reference_angle)
    );

    `MFMD_ASSERT_SAME(a_turn_step, ram_wr_en, turn_step == 17'sd0 || turn_step == 17'sd1 || turn_step == -17'sd1, "turn count moved by more than one")
    `MFMD_ASSERT_NEXT(a_fwd_same_slot, accept && in_hit && ram_wr_en && (AW'(in_match.slot) == AW'(r_s1_slot)), ram_rd == $past(ram_wr), "store read missed a write to the same motor")
    `MFMD_ASSERT_NEXT(a_first_held, r_first_taken, $stable(r_first_angle) && r_first_taken, "reference angle changed after it was latched")
    `MFMD_ASSERT_SAME(a_miss_clean, r_s2_vld && !r_s2.hit, r_s2.total == '0 && r_s2.turns == '0 && !r_s2.friction, "unmatched request carries motor state")

endmodule
`default_nettype wire

### design/mfmd_cfg.sv
// Motor ID registers on the APB port and the frame ID match.
`timescale 1ns / 1ps
`default_nettype none
module mfmd_cfg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mfmd_pkg::CFG_AW-1:0] paddr,
    input  wire logic [mfmd_pkg::APB_DW-1:0] pwdata,
    output logic      [mfmd_pkg::APB_DW-1:0] prdata,
    output logic                             pready,
    input  wire logic [mfmd_pkg::ID_W-1:0]   i_frame_id,
    output mfmd_pkg::t_match                 o_match
);
    import mfmd_pkg::*;

    t_id               r_ids [CFG_REGS];
    logic [SLOT_W-1:0] reg_idx;
    logic              wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_AW-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_REGS; i++) begin
                r_ids[i] <= CFG_RESET[i];
            end
        end else begin
            for (int i = 0; i < CFG_REGS; i++) begin
                if (wr_en && reg_idx == SLOT_W'(i)) begin
                    r_ids[i] <= pwdata[ID_W-1:0];
                end
            end
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            CFG_YAW:      prdata = APB_DW'(r_ids[0]);
            CFG_PITCH:    prdata = APB_DW'(r_ids[1]);
            CFG_TRIGGER:  prdata = APB_DW'(r_ids[2]);
            CFG_FRIC_ONE: prdata = APB_DW'(r_ids[3]);
            CFG_FRIC_TWO: prdata = APB_DW'(r_ids[4]);
            default:      prdata = '0;
        endcase
    end

    // Walk down so that the lowest matching slot wins.
    always_comb begin
        o_match = '0;
        for (int i = CFG_REGS - 1; i >= 0; i--) begin
            if (r_ids[i] == i_frame_id) begin
                o_match.hit  = 1'b1;
                o_match.slot = SLOT_W'(i);
            end
        end
    end

endmodule
`default_nettype wire

### design/mfmd_state_ram.sv
// Per-motor angle and turn store with registered read and write bypass.
`timescale 1ns / 1ps
`default_nettype none
module mfmd_state_ram #(
    parameter int DEPTH = 5,
    parameter int AW    = 3
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_rd_en,
    input  wire logic [AW-1:0]         i_rd_addr,
    output mfmd_pkg::t_slot_state      o_rd_data,
    input  wire logic                  i_wr_en,
    input  wire logic [AW-1:0]         i_wr_addr,
    input  wire mfmd_pkg::t_slot_state i_wr_data
);
    import mfmd_pkg::*;

    t_slot_state      mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    t_slot_state      r_rd_data;
    logic             r_rd_vld;
    logic             r_byp;
    t_slot_state      r_byp_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data  <= mem[i_rd_addr];
            r_byp_data <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_byp    <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
                // A write to the same entry in the read cycle has not reached the array yet.
                r_byp    <= i_wr_en && (i_wr_addr == i_rd_addr);
            end
        end
    end

    always_comb begin
        if (r_byp) begin
            o_rd_data = r_byp_data;
        end else if (r_rd_vld) begin
            o_rd_data = r_rd_data;
        end else begin
            o_rd_data = '0;
        end
    end

endmodule
`default_nettype wire

### design/mfmd_out_stage.sv
// Angle wrap and constant scaling, followed by the output register.
`timescale 1ns / 1ps
`default_nettype none
module mfmd_out_stage (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_req_vld,
    input  wire mfmd_pkg::t_s2_req              i_req,
    output logic                                o_busy,
    input  wire logic                           i_stall,
    output logic                                o_valid,
    output logic                                o_matched,
    output logic        [mfmd_pkg::SLOT_W-1:0]  o_motor_slot,
    output logic signed [15:0]                  o_rotor_speed,
    output logic signed [15:0]                  o_torque_current,
    output logic        [7:0]                   o_temperature,
    output logic signed [15:0]                  o_turn_count,
    output logic signed [mfmd_pkg::TOTAL_W-1:0] o_total_position,
    output logic signed [mfmd_pkg::FINE_W-1:0]  o_angle_fine,
    output logic signed [mfmd_pkg::VEL_W-1:0]   o_spin_rate,
    output logic signed [15:0]                  o_reference_angle
);
    import mfmd_pkg::*;

    localparam logic signed [TOTAL_W-1:0] HALF_POS = TOTAL_W'(ENC_HALF);
    localparam logic signed [TOTAL_W-1:0] HALF_NEG = -TOTAL_W'(ENC_HALF);
    localparam logic signed [FINE_W:0]    FINE_K   = (FINE_W + 1)'(FINE_GAIN);
    localparam logic signed [VEL_W:0]     VEL_K    = (VEL_W + 1)'(VEL_GAIN);

    logic                      r_vld;
    logic [ENC_BITS-1:0]       wrap_k;
    logic                      above;
    logic                      below;
    logic signed [TOTAL_W-1:0] wrapped;
    logic signed [TOTAL_W-1:0] fine_src;
    logic signed [FINE_W:0]    fine_ext;
    logic signed [FINE_W:0]    fine_full;
    logic signed [VEL_W:0]     rpm_ext;
    logic signed [VEL_W:0]     vel_full;

    assign o_busy  = r_vld && i_stall;
    assign o_valid = r_vld;

    // Wrapping 45*total by 45*8192 is the same as wrapping total by one turn,
    // so the wrap runs on the narrow position before the multiply.
    always_comb begin
        wrap_k = i_req.total[ENC_BITS-1:0] + ENC_BITS'(ENC_HALF);
        above  = i_req.total > HALF_POS;
        below  = i_req.total < HALF_NEG;
        if (above || below) begin
            if (wrap_k == '0) begin
                wrapped = above ? HALF_POS : HALF_NEG;
            end else begin
                wrapped = $signed(TOTAL_W'(wrap_k)) - HALF_POS;
            end
        end else begin
            wrapped = i_req.total;
        end
        fine_src  = i_req.friction ? wrapped : i_req.total;
        fine_ext  = (FINE_W + 1)'(fine_src);
        fine_full = fine_ext * FINE_K;
        rpm_ext   = (VEL_W + 1)'(i_req.rpm);
        vel_full  = i_req.friction ? rpm_ext * VEL_K : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (!o_busy) begin
            r_vld <= i_req_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_busy && i_req_vld) begin
            o_matched         <= i_req.hit;
            o_motor_slot      <= i_req.slot;
            o_rotor_speed     <= i_req.rpm;
            o_torque_current  <= i_req.cur;
            o_temperature     <= i_req.temp;
            o_turn_count      <= i_req.turns;
            o_total_position  <= i_req.total;
            o_angle_fine      <= fine_full[FINE_W-1:0];
            o_spin_rate       <= vel_full[VEL_W-1:0];
            o_reference_angle <= i_req.ref_angle;
        end
    end

endmodule
`default_nettype wire
